// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle as ante, outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/gbc_pkg.sv =====
package gbc_pkg;

    localparam int SAMPLE_COUNT = 1000;

    localparam int RATE_W     = 16;
    localparam int THR_W      = 16;
    localparam int BUDGET_W   = 11;
    localparam int SENS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BIAS_W     = 32;
    localparam int COUNT_W    = 10;
    localparam int DISC_W     = 11;
    localparam int QFRAC_W    = 16;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;

    localparam int ACC_W   = RATE_W + $clog2(SAMPLE_COUNT);
    localparam int TALLY_W = $clog2(SAMPLE_COUNT + 1);
    localparam int DEN_W   = SENS_W + $clog2(SAMPLE_COUNT + 1);
    localparam int NUM_W   = ACC_W + QFRAC_W;
    localparam int STEP_W  = $clog2(NUM_W + 1);
    localparam int DSUM_W  = ((TALLY_W > DISC_W) ? TALLY_W : DISC_W) + 1;

    localparam logic [THR_W-1:0]    THR_RESET    = 16'd100;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 11'd500;
    localparam logic [SENS_W-1:0]   SENS_RESET   = 16'd1880;
    localparam logic [DISC_W-1:0]   DISCARD_MAX  = '1;

    localparam logic [TALLY_W-1:0] TALLY_LAST = TALLY_W'(SAMPLE_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(SAMPLE_COUNT);
    localparam logic [AXIS_W-1:0]  AXIS_LAST  = AXIS_W'(AXES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_BUDGET    = 2'd1,
        REG_SENS      = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_COLLECT = 3'd0,
        ST_RESTART = 3'd1,
        ST_DONE    = 3'd2,
        ST_ABORT   = 3'd3,
        ST_IDLE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CNT_ZERO = 2'd0,
        CNT_NEXT = 2'd1,
        CNT_FULL = 2'd2
    } count_sel_t;

    typedef struct packed {
        logic              cap_in;
        logic              clr_run;
        logic              accum;
        logic              charge;
        logic              div_start;
        logic [AXIS_W-1:0] axis;
        logic              held_wr;
        logic              out_load;
        status_t           out_status;
        logic              out_bias;
        count_sel_t        out_count;
    } dp_cmd_t;

    typedef struct packed {
        logic start_op;
        logic jump;
        logic over_budget;
        logic tally_last;
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/gbc_div.sv =====
module gbc_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [gbc_pkg::ACC_W-1:0]     dividend,
    input  logic        [gbc_pkg::SENS_W-1:0]    sens,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [gbc_pkg::BIAS_W-1:0]    quotient
);

    logic [gbc_pkg::NUM_W-1:0]  work_reg, work_next;
    logic [gbc_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [gbc_pkg::DEN_W-1:0]  den_reg, den_next;
    logic                       neg_reg, neg_next;
    logic [gbc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [gbc_pkg::SENS_W-1:0] sens_eff;
    logic [gbc_pkg::DEN_W-1:0]  den_prod;
    logic [gbc_pkg::ACC_W-1:0]  dividend_u;
    logic [gbc_pkg::ACC_W-1:0]  mag;
    logic [gbc_pkg::DEN_W:0]    trial;
    logic [gbc_pkg::DEN_W:0]    diff;
    logic                       fits;
    logic [gbc_pkg::NUM_W-1:0]  signed_q;

    always_comb begin
        sens_eff   = (sens == '0) ? gbc_pkg::SENS_W'(1) : sens;
        den_prod   = gbc_pkg::DEN_W'(gbc_pkg::SAMPLE_COUNT) * gbc_pkg::DEN_W'(sens_eff);
        dividend_u = dividend;
        mag        = dividend_u[gbc_pkg::ACC_W-1] ? (~dividend_u + 1'b1) : dividend_u;
        trial      = {rem_reg, work_reg[gbc_pkg::NUM_W-1]};
        diff       = trial - {1'b0, den_reg};
        fits       = trial >= {1'b0, den_reg};

        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            work_next = {mag, {gbc_pkg::QFRAC_W{1'b0}}};
            rem_next  = '0;
            den_next  = den_prod;
            neg_next  = dividend_u[gbc_pkg::ACC_W-1];
            step_next = gbc_pkg::STEP_W'(gbc_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[gbc_pkg::DEN_W-1:0] : trial[gbc_pkg::DEN_W-1:0];
            work_next = {work_reg[gbc_pkg::NUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == gbc_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        signed_q = neg_reg ? (~work_reg + 1'b1) : work_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = signed_q[gbc_pkg::BIAS_W-1:0];

endmodule

// ===== src/gbc_dp.sv =====
module gbc_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [gbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   s_operation,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_x,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_y,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [2:0]                      m_status,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_x,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_y,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_z,
    output logic        [gbc_pkg::COUNT_W-1:0]     m_good_count,
    input  gbc_pkg::dp_cmd_t                       cmd,
    output gbc_pkg::dp_stat_t                      stat
);

    function automatic logic [gbc_pkg::RATE_W:0] abs_diff(
        input logic [gbc_pkg::RATE_W-1:0] a,
        input logic [gbc_pkg::RATE_W-1:0] b
    );
        logic [gbc_pkg::RATE_W:0] d;
        d = {a[gbc_pkg::RATE_W-1], a} - {b[gbc_pkg::RATE_W-1], b};
        return d[gbc_pkg::RATE_W] ? (~d + 1'b1) : d;
    endfunction

    logic [gbc_pkg::THR_W-1:0]    thr_reg, thr_next;
    logic [gbc_pkg::BUDGET_W-1:0] budget_reg, budget_next;
    logic [gbc_pkg::SENS_W-1:0]   sens_reg, sens_next;

    logic                               op_reg;
    logic signed [gbc_pkg::RATE_W-1:0]  rate_reg [gbc_pkg::AXES];
    logic signed [gbc_pkg::RATE_W-1:0]  prev_reg [gbc_pkg::AXES];
    logic signed [gbc_pkg::RATE_W-1:0]  prev_next [gbc_pkg::AXES];
    logic signed [gbc_pkg::ACC_W-1:0]   acc_reg [gbc_pkg::AXES];
    logic signed [gbc_pkg::ACC_W-1:0]   acc_next [gbc_pkg::AXES];
    logic signed [gbc_pkg::BIAS_W-1:0]  held_reg [gbc_pkg::AXES];

    logic [gbc_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic [gbc_pkg::DISC_W-1:0]  disc_reg, disc_next;

    logic                               m_valid_reg, m_valid_next;
    gbc_pkg::status_t                   m_status_reg;
    logic signed [gbc_pkg::BIAS_W-1:0]  m_bias_reg [gbc_pkg::AXES];
    logic [gbc_pkg::COUNT_W-1:0]        m_count_reg;

    logic [gbc_pkg::AXES-1:0]                     axis_jump;
    logic [gbc_pkg::TALLY_W-1:0]                  tally_inc;
    logic [gbc_pkg::TALLY_W+gbc_pkg::COUNT_W-1:0] tally_inc_wide;
    logic [gbc_pkg::DSUM_W-1:0]                   disc_sum;
    logic [gbc_pkg::DISC_W-1:0]                   disc_sat;
    logic [gbc_pkg::COUNT_W-1:0]                  count_sel;
    logic signed [gbc_pkg::ACC_W-1:0]             div_dividend;
    logic                                         div_busy;
    logic                                         div_done;
    logic signed [gbc_pkg::BIAS_W-1:0]            div_quot;

    always_comb begin
        thr_next    = thr_reg;
        budget_next = budget_reg;
        sens_next   = sens_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                gbc_pkg::REG_THRESHOLD: thr_next    = cfg_data[gbc_pkg::THR_W-1:0];
                gbc_pkg::REG_BUDGET:    budget_next = cfg_data[gbc_pkg::BUDGET_W-1:0];
                gbc_pkg::REG_SENS:      sens_next   = cfg_data[gbc_pkg::SENS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < gbc_pkg::AXES; i++) begin
            axis_jump[i] = abs_diff(rate_reg[i], prev_reg[i]) > {1'b0, thr_reg};
        end

        tally_inc      = tally_reg + 1'b1;
        tally_inc_wide = {{gbc_pkg::COUNT_W{1'b0}}, tally_inc};
        disc_sum       = gbc_pkg::DSUM_W'(disc_reg) + gbc_pkg::DSUM_W'(tally_reg);
        disc_sat       = (disc_sum > gbc_pkg::DSUM_W'(gbc_pkg::DISCARD_MAX)) ?
                         gbc_pkg::DISCARD_MAX : disc_sum[gbc_pkg::DISC_W-1:0];

        for (int i = 0; i < gbc_pkg::AXES; i++) begin
            prev_next[i] = prev_reg[i];
            acc_next[i]  = acc_reg[i];
            if (cmd.clr_run) begin
                prev_next[i] = '0;
                acc_next[i]  = '0;
            end else if (cmd.accum) begin
                prev_next[i] = rate_reg[i];
                acc_next[i]  = acc_reg[i] +
                    {{(gbc_pkg::ACC_W-gbc_pkg::RATE_W){rate_reg[i][gbc_pkg::RATE_W-1]}},
                     rate_reg[i]};
            end
        end

        tally_next = tally_reg;
        if (cmd.clr_run) begin
            tally_next = '0;
        end else if (cmd.accum) begin
            tally_next = tally_inc;
        end

        disc_next = cmd.charge ? disc_sat : disc_reg;

        unique case (cmd.out_count)
            gbc_pkg::CNT_NEXT: count_sel = tally_inc_wide[gbc_pkg::COUNT_W-1:0];
            gbc_pkg::CNT_FULL: count_sel = gbc_pkg::COUNT_FULL;
            default:           count_sel = '0;
        endcase

        unique case (cmd.axis)
            2'd1:    div_dividend = acc_reg[1];
            2'd2:    div_dividend = acc_reg[2];
            default: div_dividend = acc_reg[0];
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    gbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .sens     (sens_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= gbc_pkg::THR_RESET;
            budget_reg  <= gbc_pkg::BUDGET_RESET;
            sens_reg    <= gbc_pkg::SENS_RESET;
            tally_reg   <= '0;
            disc_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < gbc_pkg::AXES; i++) begin
                prev_reg[i] <= '0;
                acc_reg[i]  <= '0;
            end
        end else begin
            thr_reg     <= thr_next;
            budget_reg  <= budget_next;
            sens_reg    <= sens_next;
            tally_reg   <= tally_next;
            disc_reg    <= disc_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < gbc_pkg::AXES; i++) begin
                prev_reg[i] <= prev_next[i];
                acc_reg[i]  <= acc_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            op_reg      <= s_operation;
            rate_reg[0] <= s_rate_x;
            rate_reg[1] <= s_rate_y;
            rate_reg[2] <= s_rate_z;
        end
        if (cmd.held_wr) begin
            held_reg[cmd.axis] <= div_quot;
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_count_reg  <= count_sel;
            for (int i = 0; i < gbc_pkg::AXES; i++) begin
                m_bias_reg[i] <= cmd.out_bias ? held_reg[i] : '0;
            end
        end
    end

    always_comb begin
        stat.start_op    = op_reg;
        stat.jump        = |axis_jump;
        stat.over_budget = disc_sat > budget_reg;
        stat.tally_last  = tally_reg >= gbc_pkg::TALLY_LAST;
        stat.div_busy    = div_busy;
        stat.div_done    = div_done;
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_bias_x     = m_bias_reg[0];
    assign m_bias_y     = m_bias_reg[1];
    assign m_bias_z     = m_bias_reg[2];
    assign m_good_count = m_count_reg;

endmodule

// ===== src/gbc_ctrl.sv =====
module gbc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gbc_pkg::dp_stat_t  stat,
    output gbc_pkg::dp_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EVAL     = 5'b00010,
        S_DIV_GO   = 5'b00100,
        S_DIV_WAIT = 5'b01000,
        S_FINISH   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_COLLECT = 4'b0010,
        PH_DONE    = 4'b0100,
        PH_ABORT   = 4'b1000
    } phase_t;

    state_t                      state_reg, state_next;
    phase_t                      phase_reg, phase_next;
    logic [gbc_pkg::AXIS_W-1:0]  axis_reg, axis_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                    cmd.out_load = 1'b1;
                    priority if (stat.start_op) begin
                        cmd.clr_run    = 1'b1;
                        cmd.out_status = gbc_pkg::ST_COLLECT;
                        phase_next     = PH_COLLECT;
                    end else if (phase_reg == PH_IDLE) begin
                        cmd.out_status = gbc_pkg::ST_IDLE;
                    end else if (phase_reg == PH_DONE) begin
                        cmd.out_status = gbc_pkg::ST_DONE;
                        cmd.out_bias   = 1'b1;
                        cmd.out_count  = gbc_pkg::CNT_FULL;
                    end else if (phase_reg == PH_ABORT) begin
                        cmd.out_status = gbc_pkg::ST_ABORT;
                    end else if (stat.jump) begin
                        cmd.charge  = 1'b1;
                        cmd.clr_run = 1'b1;
                        if (stat.over_budget) begin
                            cmd.out_status = gbc_pkg::ST_ABORT;
                            phase_next     = PH_ABORT;
                        end else begin
                            cmd.out_status = gbc_pkg::ST_RESTART;
                        end
                    end else begin
                        cmd.accum = 1'b1;
                        if (stat.tally_last) begin
                            cmd.out_load = 1'b0;
                            axis_next    = '0;
                            state_next   = S_DIV_GO;
                        end else begin
                            cmd.out_status = gbc_pkg::ST_COLLECT;
                            cmd.out_count  = gbc_pkg::CNT_NEXT;
                        end
                    end
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.held_wr = 1'b1;
                    if (axis_reg == gbc_pkg::AXIS_LAST) begin
                        state_next = S_FINISH;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = gbc_pkg::ST_DONE;
                    cmd.out_bias   = 1'b1;
                    cmd.out_count  = gbc_pkg::CNT_FULL;
                    phase_next     = PH_DONE;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ===== src/gyro_still_bias_calibrator_top.sv =====
// Still-bias calibrator for a three-axis gyroscope: every accepted item returns exactly
// one result. An item is captured in S_IDLE and evaluated in S_EVAL, and no new item is
// accepted until the last one has been evaluated; a finished result sits in the output
// register while the next item is accepted, and evaluation waits only if that register
// is still full. The sample that completes a run instead starts a shared restoring
// divider that yields one quotient bit per cycle, NUM_W bits (42 at 1000 samples) for
// each axis in turn, and its result appears once all three axes are divided.
// Configuration writes are taken in any cycle, are meant to happen only while the block
// is idle, and act from the next cycle.
`include "assert_macros.svh"

module gyro_still_bias_calibrator_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [gbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_operation,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_x,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_y,
    input  logic signed [gbc_pkg::RATE_W-1:0]      s_rate_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [2:0]                      m_status,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_x,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_y,
    output logic signed [gbc_pkg::BIAS_W-1:0]      m_bias_z,
    output logic        [gbc_pkg::COUNT_W-1:0]     m_good_count
);

    gbc_pkg::dp_cmd_t  cmd;
    gbc_pkg::dp_stat_t stat;

    gbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gbc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_operation  (s_operation),
        .s_rate_x     (s_rate_x),
        .s_rate_y     (s_rate_y),
        .s_rate_z     (s_rate_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_bias_x     (m_bias_x),
        .m_bias_y     (m_bias_y),
        .m_bias_z     (m_bias_z),
        .m_good_count (m_good_count),
        .cmd          (cmd),
        .stat         (stat)
    );

    `ASSERT_IMPLIES(a_load_into_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready)
    `ASSERT_IMPLIES(a_no_accept_in_div, aclk, aresetn, s_ready, !stat.div_busy)
    `ASSERT_NEXT(a_div_runs, aclk, aresetn, cmd.div_start, stat.div_busy)
    `ASSERT_IMPLIES(a_done_count, aclk, aresetn, m_valid && m_status == gbc_pkg::ST_DONE, m_good_count == gbc_pkg::COUNT_FULL)
    `ASSERT_IMPLIES(a_bias_only_done, aclk, aresetn, m_valid && m_status != gbc_pkg::ST_DONE, m_bias_x == 0 && m_bias_y == 0 && m_bias_z == 0)

endmodule

// ===== dv/gbc_result_checker.sv =====
`timescale 1ns / 1ps

module gbc_result_checker
    import gbc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic       [CFG_DATA_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_operation,
    input  logic signed    [RATE_W-1:0] s_rate_x,
    input  logic signed    [RATE_W-1:0] s_rate_y,
    input  logic signed    [RATE_W-1:0] s_rate_z,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                  [2:0] m_status,
    input  logic signed    [BIAS_W-1:0] m_bias_x,
    input  logic signed    [BIAS_W-1:0] m_bias_y,
    input  logic signed    [BIAS_W-1:0] m_bias_z,
    input  logic          [COUNT_W-1:0] m_good_count,
    output int                          n_failures,
    output int                          n_pending,
    output int                          n_checked
);

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_COLLECT,
        RUN_DONE,
        RUN_ABORT
    } run_phase_t;

    typedef struct packed {
        status_t            status;
        logic [BIAS_W-1:0]  bias_x;
        logic [BIAS_W-1:0]  bias_y;
        logic [BIAS_W-1:0]  bias_z;
        logic [COUNT_W-1:0] good_count;
    } calib_result_t;

    int                jump_limit;
    int                budget;
    int                sens;
    int                last_rate [AXES];
    longint            rate_sum [AXES];
    int                run_count;
    int                discarded;
    run_phase_t        run_phase;
    logic [BIAS_W-1:0] held_bias [AXES];
    calib_result_t     bias_results_q [$];

    function automatic void clear_run();
        for (int a = 0; a < AXES; a++) begin
            last_rate[a] = 0;
            rate_sum[a]  = 0;
        end
        run_count = 0;
    endfunction

    function automatic calib_result_t predict_result(input logic op,
            input logic signed [RATE_W-1:0] rx, input logic signed [RATE_W-1:0] ry,
            input logic signed [RATE_W-1:0] rz);
        calib_result_t r;
        int            smp [AXES];
        int            d;
        bit            jumped;
        longint        den;
        r.status     = ST_COLLECT;
        r.bias_x     = '0;
        r.bias_y     = '0;
        r.bias_z     = '0;
        r.good_count = '0;
        smp[0] = int'(rx);
        smp[1] = int'(ry);
        smp[2] = int'(rz);
        jumped = 1'b0;
        if (op) begin
            clear_run();
            run_phase = RUN_COLLECT;
        end else begin
            case (run_phase)
                RUN_IDLE: r.status = ST_IDLE;
                RUN_ABORT: r.status = ST_ABORT;
                RUN_DONE: begin
                    r.status     = ST_DONE;
                    r.bias_x     = held_bias[0];
                    r.bias_y     = held_bias[1];
                    r.bias_z     = held_bias[2];
                    r.good_count = COUNT_W'(SAMPLE_COUNT);
                end
                default: begin
                    for (int a = 0; a < AXES; a++) begin
                        d = smp[a] - last_rate[a];
                        if (d < 0) d = -d;
                        if (d > jump_limit) jumped = 1'b1;
                    end
                    if (jumped) begin
                        discarded += run_count;
                        if (discarded > int'(DISCARD_MAX)) discarded = int'(DISCARD_MAX);
                        clear_run();
                        if (discarded > budget) begin
                            run_phase = RUN_ABORT;
                            r.status  = ST_ABORT;
                        end else begin
                            r.status = ST_RESTART;
                        end
                    end else begin
                        for (int a = 0; a < AXES; a++) begin
                            rate_sum[a] += longint'(smp[a]);
                            last_rate[a] = smp[a];
                        end
                        run_count++;
                        r.good_count = COUNT_W'(run_count);
                        if (run_count >= SAMPLE_COUNT) begin
                            den = longint'(SAMPLE_COUNT) * longint'((sens == 0) ? 1 : sens);
                            for (int a = 0; a < AXES; a++)
                                held_bias[a] = BIAS_W'((rate_sum[a] * 64'sd65536) / den);
                            run_phase = RUN_DONE;
                            r.status  = ST_DONE;
                            r.bias_x  = held_bias[0];
                            r.bias_y  = held_bias[1];
                            r.bias_z  = held_bias[2];
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            n_failures++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        calib_result_t want;
        if (!aresetn) begin
            jump_limit = int'(THR_RESET);
            budget     = int'(BUDGET_RESET);
            sens       = int'(SENS_RESET);
            clear_run();
            discarded  = 0;
            run_phase  = RUN_IDLE;
            for (int a = 0; a < AXES; a++) held_bias[a] = '0;
            bias_results_q.delete();
            n_failures = 0;
            n_pending  = 0;
            n_checked  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (bias_results_q.size() == 0) begin
                    n_failures++;
                    $display("%0t unexpected result: expected none, actual status %0d",
                             $time, m_status);
                end else begin
                    want = bias_results_q.pop_front();
                    check_field("status", longint'(want.status), longint'(m_status));
                    check_field("bias_x", longint'($signed(want.bias_x)), longint'(m_bias_x));
                    check_field("bias_y", longint'($signed(want.bias_y)), longint'(m_bias_y));
                    check_field("bias_z", longint'($signed(want.bias_z)), longint'(m_bias_z));
                    check_field("good_count", longint'(want.good_count),
                                longint'(m_good_count));
                    n_checked++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: jump_limit = int'(cfg_data);
                    REG_BUDGET: budget = int'(cfg_data[BUDGET_W-1:0]);
                    REG_SENS: sens = int'(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                bias_results_q.push_back(predict_result(s_operation, s_rate_x, s_rate_y,
                                                        s_rate_z));
            n_pending = bias_results_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gbc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;
    localparam int END_WAIT    = 150;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic         [CFG_IDX_W-1:0] cfg_index;
    logic        [CFG_DATA_W-1:0] cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_operation;
    logic signed     [RATE_W-1:0] s_rate_x;
    logic signed     [RATE_W-1:0] s_rate_y;
    logic signed     [RATE_W-1:0] s_rate_z;
    logic                         m_valid;
    logic                         m_ready;
    logic                   [2:0] m_status;
    logic signed     [BIAS_W-1:0] m_bias_x;
    logic signed     [BIAS_W-1:0] m_bias_y;
    logic signed     [BIAS_W-1:0] m_bias_z;
    logic           [COUNT_W-1:0] m_good_count;

    int n_failures;
    int n_pending;
    int n_checked;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int items_sent;
    int cycle_count;
    logic signed [RATE_W-1:0] walk [AXES];

    gyro_still_bias_calibrator_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_rate_x     (s_rate_x),
        .s_rate_y     (s_rate_y),
        .s_rate_z     (s_rate_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_bias_x     (m_bias_x),
        .m_bias_y     (m_bias_y),
        .m_bias_z     (m_bias_z),
        .m_good_count (m_good_count)
    );

    gbc_result_checker result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_rate_x     (s_rate_x),
        .s_rate_y     (s_rate_y),
        .s_rate_z     (s_rate_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_bias_x     (m_bias_x),
        .m_bias_y     (m_bias_y),
        .m_bias_z     (m_bias_z),
        .m_good_count (m_good_count),
        .n_failures   (n_failures),
        .n_pending    (n_pending),
        .n_checked    (n_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("gyro_still_bias_calibrator_top test failed");
        $finish;
    end

    initial begin : result_sink
        int hold_seen;
        hold_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
        end
    end

    function automatic logic signed [RATE_W-1:0] step_rate(
            input logic signed [RATE_W-1:0] cur, input int lim);
        int v;
        if ($urandom_range(0, 7) == 0)
            v = ($urandom_range(0, 1) == 0) ? int'(cur) + lim : int'(cur) - lim;
        else
            v = int'(cur) + int'($urandom_range(0, 2 * lim)) - lim;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return RATE_W'(v);
    endfunction

    function automatic logic signed [RATE_W-1:0] jump_rate(
            input logic signed [RATE_W-1:0] cur, input int lim);
        int v;
        v = int'(cur) + lim + 1 + int'($urandom_range(0, 3));
        if (v > 32767) v = int'(cur) - lim - 1 - int'($urandom_range(0, 3));
        if (v < -32768) v = -32768;
        return RATE_W'(v);
    endfunction

    function automatic logic signed [RATE_W-1:0] wild_rate();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 15) return 16'sh7FFF;
        if (r < 30) return 16'sh8000;
        return RATE_W'($urandom);
    endfunction

    task automatic send_item(input logic op, input logic signed [RATE_W-1:0] rx,
            input logic signed [RATE_W-1:0] ry, input logic signed [RATE_W-1:0] rz);
        while (int'($urandom_range(0, 99)) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_rate_x    <= rx;
        s_rate_y    <= ry;
        s_rate_z    <= rz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_start();
        send_item(1'b1, RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
        walk = '{default: '0};
    endtask

    task automatic send_noise();
        send_item(1'($urandom_range(0, 1)), RATE_W'($urandom), RATE_W'($urandom),
                  RATE_W'($urandom));
        walk = '{default: '0};
    endtask

    task automatic take_step(input int lim);
        for (int a = 0; a < AXES; a++) walk[a] = step_rate(walk[a], lim);
        send_item(1'b0, walk[0], walk[1], walk[2]);
    endtask

    task automatic send_jump(input int lim);
        int a;
        a = int'($urandom_range(0, AXES - 1));
        walk[a] = jump_rate(walk[a], lim);
        send_item(1'b0, walk[0], walk[1], walk[2]);
        walk = '{default: '0};
    endtask

    // bursts of in-limit samples broken by starts, junk items and jumps
    task automatic random_mix(input int n, input int lim);
        int sent;
        int burst;
        int r;
        send_start();
        sent = 1;
        while (sent < n) begin
            burst = int'($urandom_range(1, 60));
            repeat (burst) take_step(lim);
            sent += burst;
            r = int'($urandom_range(0, 99));
            if (r < 15) send_start();
            else if (r < 35) send_noise();
            else send_jump(lim);
            sent++;
        end
    endtask

    task automatic good_run(input int n, input int lim);
        send_start();
        repeat (n) take_step(lim);
        send_jump(lim);
    endtask

    task automatic full_run();
        send_start();
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (i == SAMPLE_COUNT / 3) hold_req++;
            send_item(1'b0, wild_rate(), wild_rate(), wild_rate());
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_regs(input int thr, input int budget, input int sens);
        cfg_reg_t              regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs[0] = REG_THRESHOLD;
        regs[1] = REG_BUDGET;
        regs[2] = REG_SENS;
        vals[0] = CFG_DATA_W'(thr);
        vals[1] = CFG_DATA_W'(budget);
        vals[2] = CFG_DATA_W'(sens);
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int lim;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_THRESHOLD;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_operation = 1'b0;
        s_rate_x    = '0;
        s_rate_y    = '0;
        s_rate_z    = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 0;
        items_sent  = 0;
        walk        = '{default: '0};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000);
        send_item(1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_item(1'b1, 16'sh8000, 16'sh7FFF, 16'shFFFF);
        send_item(1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(1'b0, 16'sd100, -16'sd100, 16'sd0);
        send_item(1'b0, 16'sd100, -16'sd100, 16'sd101);
        send_item(1'b0, 16'sh8000, 16'sh0000, 16'sh0000);
        send_item(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(1'b0, -16'sd100, 16'sd0, 16'sd100);
        send_item(1'b0, -16'sd50, 16'sd50, 16'sd150);
        send_item(1'b1, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(1'b0, 16'sd1, 16'sd2, 16'sd3);
        send_item(1'b0, 16'sd1, 16'sd2, 16'sd3);
        write_regs(0, 0, 1);
        send_item(1'b0, 16'sd1, 16'sd2, 16'sd3);
        send_item(1'b0, 16'sd1, 16'sd2, 16'sd4);
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd0);
        send_item(1'b1, 16'sh5555, 16'shAAAA, 16'sh0F0F);
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd0);
        send_item(1'b0, 16'sd0, 16'sd0, -16'sd1);

        lim = int'($urandom_range(50, 2000));
        write_regs(lim, 1000, int'($urandom_range(1000, 3000)));
        idle_pct  = 9;
        stall_pct = 9;
        random_mix(100, lim);
        wait_idle();
        idle_pct  = 76;
        stall_pct = 0;
        random_mix(100, lim);

        // full calibration, long output stall partway through
        write_regs(65535, 2047, 0);
        idle_pct = 0;
        full_run();
        repeat (20) send_item(1'b0, wild_rate(), wild_rate(), wild_rate());

        write_regs(1, int'($urandom_range(0, 65535)), 1);
        stall_pct = 76;
        random_mix(120, 1);

        // long runs thrown away to build up the discard total
        write_regs(300, 2047, 65535);
        idle_pct  = 76;
        stall_pct = 0;
        good_run(80, 300);
        idle_pct  = 0;
        stall_pct = 76;
        good_run(80, 300);
        idle_pct  = 9;
        stall_pct = 9;
        good_run(80, 300);
        idle_pct  = 0;
        stall_pct = 0;
        random_mix(50, 300);

        lim = int'($urandom_range(0, 500));
        write_regs(lim, int'($urandom_range(0, 1000)), 65535);
        idle_pct  = 9;
        stall_pct = 9;
        random_mix(60, lim);

        wait_idle();
        repeat (END_WAIT) @(negedge aclk);
        $display("Sent %0d items, checked %0d results: idle, start, restart, abort, done,",
                 items_sent, n_checked);
        $display("discard build-up over long runs and register extremes under varied pacing");
        if (n_failures == 0)
            $display("gyro_still_bias_calibrator_top test passed");
        else
            $display("gyro_still_bias_calibrator_top test failed");
        $finish;
    end

endmodule
